/* design/imufd_pkg.sv */
// ---------------------------------------------------------------------------
// imufd_pkg: shared types and constants of the IMU serial frame decoder
// Holds the frame layout constants, the frame kind codes and the control
// struct that the decoder hands to its axis scaling lanes.
// ---------------------------------------------------------------------------
package imufd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned FS_W       = 12;
  localparam int unsigned RAW_W      = 16;
  localparam int unsigned AXIS_W     = 28;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned SUM_LEN    = 10;
  localparam int unsigned NUM_CELLS  = 10;

  localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'h55;
  localparam logic [BYTE_W-1:0] TYPE_ACCEL = 8'h51;
  localparam logic [BYTE_W-1:0] TYPE_GYRO  = 8'h52;
  localparam logic [BYTE_W-1:0] TYPE_ANGLE = 8'h53;
  localparam logic [BYTE_W-1:0] TYPE_MAG   = 8'h54;

  localparam logic [POS_W-1:0] POS_HUNT     = 4'd0;
  localparam logic [POS_W-1:0] POS_CHECKSUM = 4'd10;

  localparam logic [KIND_W-1:0] KIND_ACCEL = 3'd0;
  localparam logic [KIND_W-1:0] KIND_GYRO  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ANGLE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MAG   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_OTHER = 3'd4;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_ACCEL_FS = 2'd0;
  localparam logic [1:0] REG_GYRO_FS  = 2'd1;
  localparam logic [1:0] REG_ANGLE_FS = 2'd2;
  localparam logic [1:0] REG_MAG_FS   = 2'd3;

  localparam logic [FS_W-1:0] ACCEL_FS_RESET = 12'd16;
  localparam logic [FS_W-1:0] GYRO_FS_RESET  = 12'd2000;
  localparam logic [FS_W-1:0] ANGLE_FS_RESET = 12'd180;
  localparam logic [FS_W-1:0] MAG_FS_RESET   = 12'd2;

  typedef struct packed {
    logic            load;
    logic [FS_W-1:0] fs;
  } scale_ctl_t;

endpackage

/* design/imufd_byte_cell.sv */
// ---------------------------------------------------------------------------
// imufd_byte_cell: one byte cell of the frame shift chain
// Takes the byte of its upstream neighbor on every shift and offers its own
// byte to the downstream neighbor.
// ---------------------------------------------------------------------------
module imufd_byte_cell
  import imufd_pkg::*;
(
  input  logic              clk,
  input  logic              shift,
  input  logic [BYTE_W-1:0] d,
  output logic [BYTE_W-1:0] q
);

  logic [BYTE_W-1:0] data;

  always_ff @(posedge clk) begin
    if (shift) begin
      data <= d;
    end
  end

  assign q = data;

endmodule

/* design/imufd_scale_lane.sv */
// ---------------------------------------------------------------------------
// imufd_scale_lane: one axis scaling lane
// Multiplies a signed raw axis count by the unsigned full scale of the frame
// kind and holds the product for the output transfer.
// ---------------------------------------------------------------------------
module imufd_scale_lane
  import imufd_pkg::*;
(
  input  logic              clk,
  input  scale_ctl_t        ctl,
  input  logic [RAW_W-1:0]  raw,
  output logic [AXIS_W-1:0] scaled
);

  logic signed [RAW_W+FS_W:0] product;
  logic [AXIS_W-1:0]          result;

  // The zero-extended full scale keeps the product signed and exact.
  assign product = $signed(raw) * $signed({1'b0, ctl.fs});

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      result <= product[AXIS_W-1:0];
    end
  end

  assign scaled = result;

endmodule

/* design/imu_serial_frame_decoder_unit.sv */
// ---------------------------------------------------------------------------
// imu_serial_frame_decoder_unit: IMU 11-byte serial frame decoder
// Bytes from the receiver enter on the input channel (in_valid, in_stall,
// rx_byte), one per transfer. The decoder hunts for the sync byte, shifts
// ten frame bytes through a chain of byte cells while keeping a running
// sum, and checks the eleventh byte against that sum. A good frame yields
// one result on the output channel (out_valid, out_stall and the result
// fields); a bad frame is dropped and the decoder hunts for sync again.
// One byte is taken per cycle while in_stall is low. The result appears
// in the cycle after the checksum byte is taken; the three axis multipliers
// sit in front of the output register. While a result waits on a stalled
// receiver, bytes keep flowing in; only a checksum byte is held back until
// the output register is free. Reset returns the decoder to sync hunting,
// empties the output and restores the full scale registers, which the APB
// port writes and reads at byte addresses 0, 4, 8 and 12.
// ---------------------------------------------------------------------------
module imu_serial_frame_decoder_unit
  import imufd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KIND_W-1:0] frame_kind,
  output logic [BYTE_W-1:0] type_code,
  output logic [AXIS_W-1:0] x_scaled,
  output logic [AXIS_W-1:0] y_scaled,
  output logic [AXIS_W-1:0] z_scaled,
  output logic [RAW_W-1:0]  temp_centi
);

  logic [FS_W-1:0]   accel_fs;
  logic [FS_W-1:0]   gyro_fs;
  logic [FS_W-1:0]   angle_fs;
  logic [FS_W-1:0]   mag_fs;
  logic [POS_W-1:0]  position;
  logic [POS_W-1:0]  position_next;
  logic [BYTE_W-1:0] running_sum;
  logic [BYTE_W-1:0] running_sum_next;
  logic              result_valid;
  logic [KIND_W-1:0] kind_reg;
  logic [BYTE_W-1:0] type_reg;
  logic [RAW_W-1:0]  temp_reg;

  logic              cfg_write;
  logic [1:0]        cfg_index;
  logic              in_xfer;
  logic              out_xfer;
  logic              hunting;
  logic              shift;
  logic              frame_good;
  logic [KIND_W-1:0] kind_sel;
  scale_ctl_t        scale_ctl;

  logic [BYTE_W-1:0] cell_q [NUM_CELLS];

  // ---------------- configuration port ----------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_fs <= ACCEL_FS_RESET;
      gyro_fs  <= GYRO_FS_RESET;
      angle_fs <= ANGLE_FS_RESET;
      mag_fs   <= MAG_FS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ACCEL_FS: accel_fs <= pwdata[FS_W-1:0];
        REG_GYRO_FS:  gyro_fs  <= pwdata[FS_W-1:0];
        REG_ANGLE_FS: angle_fs <= pwdata[FS_W-1:0];
        REG_MAG_FS:   mag_fs   <= pwdata[FS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_index)
      REG_ACCEL_FS: prdata[FS_W-1:0] = accel_fs;
      REG_GYRO_FS:  prdata[FS_W-1:0] = gyro_fs;
      REG_ANGLE_FS: prdata[FS_W-1:0] = angle_fs;
      REG_MAG_FS:   prdata[FS_W-1:0] = mag_fs;
      default:      prdata = '0;
    endcase
  end

  // ---------------- frame parser ----------------
  // A checksum byte waits while the output register still holds a result.
  assign in_stall = result_valid && (position == POS_CHECKSUM);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = result_valid && !out_stall;

  // A position past the checksum slot is treated as hunting.
  assign hunting = (position == POS_HUNT) || (position > POS_CHECKSUM);
  assign shift   = in_xfer && (hunting ? (rx_byte == SYNC_BYTE) : (position < POS_CHECKSUM));
  assign frame_good = in_xfer && !hunting && (position == POS_CHECKSUM)
                      && (rx_byte == running_sum);

  always_comb begin
    position_next    = position;
    running_sum_next = running_sum;
    if (in_xfer) begin
      priority if (hunting) begin
        if (rx_byte == SYNC_BYTE) begin
          position_next    = POS_HUNT + 4'd1;
          running_sum_next = rx_byte;
        end else begin
          position_next    = POS_HUNT;
          running_sum_next = '0;
        end
      end else if (position < POS_CHECKSUM) begin
        position_next    = position + 4'd1;
        running_sum_next = running_sum + rx_byte;
      end else begin
        position_next    = POS_HUNT;
        running_sum_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= POS_HUNT;
      running_sum <= '0;
    end else begin
      position    <= position_next;
      running_sum <= running_sum_next;
    end
  end

  // Cell 0 takes the newest byte; after ten shifts cell k holds frame byte 9-k.
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    imufd_byte_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .d     ((k == 0) ? rx_byte : cell_q[(k == 0) ? 0 : k-1]),
      .q     (cell_q[k])
    );
  end

  // ---------------- kind decode and scaling ----------------
  always_comb begin
    scale_ctl.load = frame_good;
    unique case (cell_q[8])
      TYPE_ACCEL: begin kind_sel = KIND_ACCEL; scale_ctl.fs = accel_fs; end
      TYPE_GYRO:  begin kind_sel = KIND_GYRO;  scale_ctl.fs = gyro_fs;  end
      TYPE_ANGLE: begin kind_sel = KIND_ANGLE; scale_ctl.fs = angle_fs; end
      TYPE_MAG:   begin kind_sel = KIND_MAG;   scale_ctl.fs = mag_fs;   end
      default:    begin kind_sel = KIND_OTHER; scale_ctl.fs = '0;       end
    endcase
  end

  imufd_scale_lane u_lane_x (
    .clk    (clk),
    .ctl    (scale_ctl),
    .raw    ({cell_q[6], cell_q[7]}),
    .scaled (x_scaled)
  );

  imufd_scale_lane u_lane_y (
    .clk    (clk),
    .ctl    (scale_ctl),
    .raw    ({cell_q[4], cell_q[5]}),
    .scaled (y_scaled)
  );

  imufd_scale_lane u_lane_z (
    .clk    (clk),
    .ctl    (scale_ctl),
    .raw    ({cell_q[2], cell_q[3]}),
    .scaled (z_scaled)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (frame_good) begin
      kind_reg <= kind_sel;
      type_reg <= cell_q[8];
      temp_reg <= {cell_q[0], cell_q[1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (frame_good) begin
      result_valid <= 1'b1;
    end else if (out_xfer) begin
      result_valid <= 1'b0;
    end
  end

  assign out_valid  = result_valid;
  assign frame_kind = kind_reg;
  assign type_code  = type_reg;
  assign temp_centi = temp_reg;

  // ---------------- assertions ----------------
  a_position_range: assert property (@(posedge clk) disable iff (rst)
    position <= POS_CHECKSUM)
    else $error("byte position left the frame");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    frame_good |-> !result_valid)
    else $error("good frame would overwrite a pending result");

  a_other_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && frame_kind == KIND_OTHER)
      |-> (x_scaled == '0 && y_scaled == '0 && z_scaled == '0))
    else $error("axes of an unknown frame kind are not zero");

  a_sync_first: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && hunting && rx_byte != SYNC_BYTE) |=> (position == POS_HUNT))
    else $error("parser left hunting on a byte other than sync");

  a_result_after_check: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(position) == POS_CHECKSUM && position == POS_HUNT))
    else $error("result raised outside a checksum byte");

endmodule

/* tb/sv/tb.sv */
// ---------------------------------------------------------------------------
// tb: regression bench for the IMU serial frame decoder
// Sends serial bytes into the decoder, both as well-formed frames with random
// contents and as noise, truncated frames and bad checksums. A bench-side
// decoder tracks sync, checksum and scaling and queues the expected results.
// Each result transfer is compared field by field with the oldest entry.
// The full scale registers are written and read back over APB between phases.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import imufd_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 8;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] code;
    logic [AXIS_W-1:0] x;
    logic [AXIS_W-1:0] y;
    logic [AXIS_W-1:0] z;
    logic [RAW_W-1:0]  temp;
  } imu_result_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [3:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid;
  logic              in_stall;
  logic [BYTE_W-1:0] rx_byte;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [KIND_W-1:0] frame_kind;
  logic [BYTE_W-1:0] type_code;
  logic [AXIS_W-1:0] x_scaled;
  logic [AXIS_W-1:0] y_scaled;
  logic [AXIS_W-1:0] z_scaled;
  logic [RAW_W-1:0]  temp_centi;

  // Bench-side decoder state.
  logic [FS_W-1:0]   full_scale [4];
  logic [POS_W-1:0]  frame_pos;
  logic [BYTE_W-1:0] frame_buf [NUM_CELLS];
  logic [BYTE_W-1:0] frame_sum;
  imu_result_t       pending_results [$];

  int in_gap_pct     = 25;
  int out_stall_pct  = 25;
  int bytes_sent     = 0;
  int results_seen   = 0;
  int frames_dropped = 0;
  int error_count    = 0;
  int idle_cycles    = 0;

  always #2 clk = ~clk;

  imu_serial_frame_decoder_unit dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_kind (frame_kind),
    .type_code  (type_code),
    .x_scaled   (x_scaled),
    .y_scaled   (y_scaled),
    .z_scaled   (z_scaled),
    .temp_centi (temp_centi)
  );

  function automatic logic [AXIS_W-1:0] scale_axis(input logic [BYTE_W-1:0] lo,
                                                   input logic [BYTE_W-1:0] hi,
                                                   input logic [FS_W-1:0] fs);
    int raw;
    int fsv;
    int prod;
    raw  = $signed({hi, lo});
    fsv  = fs;
    prod = raw * fsv;
    return prod[AXIS_W-1:0];
  endfunction

  function automatic void decode_byte(input logic [BYTE_W-1:0] b);
    imu_result_t r;
    logic [FS_W-1:0] fs;
    if (frame_pos == POS_HUNT && b != SYNC_BYTE) return;
    if (frame_pos != POS_CHECKSUM) begin
      frame_buf[frame_pos] = b;
      frame_sum += b;
      frame_pos++;
      return;
    end
    frame_pos = POS_HUNT;
    if (b != frame_sum) begin
      frame_sum = '0;
      frames_dropped++;
      return;
    end
    frame_sum = '0;
    r.code = frame_buf[1];
    case (frame_buf[1])
      TYPE_ACCEL: begin
        r.kind = KIND_ACCEL;
        fs = full_scale[REG_ACCEL_FS];
      end
      TYPE_GYRO: begin
        r.kind = KIND_GYRO;
        fs = full_scale[REG_GYRO_FS];
      end
      TYPE_ANGLE: begin
        r.kind = KIND_ANGLE;
        fs = full_scale[REG_ANGLE_FS];
      end
      TYPE_MAG: begin
        r.kind = KIND_MAG;
        fs = full_scale[REG_MAG_FS];
      end
      default: begin
        r.kind = KIND_OTHER;
        fs = '0;
      end
    endcase
    r.x    = scale_axis(frame_buf[2], frame_buf[3], fs);
    r.y    = scale_axis(frame_buf[4], frame_buf[5], fs);
    r.z    = scale_axis(frame_buf[6], frame_buf[7], fs);
    r.temp = {frame_buf[9], frame_buf[8]};
    pending_results.push_back(r);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return RAW_W'($urandom);
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] pick_type();
    int r;
    r = $urandom_range(11);
    if (r >= 10) return BYTE_W'($urandom);
    case (r % 4)
      0: return TYPE_ACCEL;
      1: return TYPE_GYRO;
      2: return TYPE_ANGLE;
      default: return TYPE_MAG;
    endcase
  endfunction

  // Result side: check each transfer, then pick the stall for the next cycle.
  always @(posedge clk) begin
    imu_result_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: kind %0d type %0h", frame_kind, type_code);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        check_field("frame_kind", 32'(want.kind), 32'(frame_kind));
        check_field("type_code", 32'(want.code), 32'(type_code));
        check_field("x_scaled", 32'(want.x), 32'(x_scaled));
        check_field("y_scaled", 32'(want.y), 32'(y_scaled));
        check_field("z_scaled", 32'(want.z), 32'(z_scaled));
        check_field("temp_centi", 32'(want.temp), 32'(temp_centi));
      end
    end
    out_stall <= !rst && ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    decode_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] tcode, input logic [RAW_W-1:0] xr,
                            input logic [RAW_W-1:0] yr, input logic [RAW_W-1:0] zr,
                            input logic [RAW_W-1:0] tr, input bit corrupt);
    logic [BYTE_W-1:0] frame_img [11];
    logic [BYTE_W-1:0] sum;
    int i;
    frame_img = '{SYNC_BYTE, tcode, xr[7:0], xr[15:8], yr[7:0], yr[15:8],
                  zr[7:0], zr[15:8], tr[7:0], tr[15:8], 8'h00};
    sum = '0;
    for (i = 0; i < 10; i++) sum += frame_img[i];
    frame_img[10] = corrupt ? (sum ^ (8'h01 << $urandom_range(7))) : sum;
    for (i = 0; i < 11; i++) send_byte(frame_img[i]);
  endtask

  // Mostly clean frames; some line noise and frames cut short.
  task automatic run_traffic(input int n_items);
    int stop_at;
    int k;
    int n_extra;
    stop_at = bytes_sent + n_items;
    while (bytes_sent < stop_at) begin
      k = $urandom_range(99);
      if (k < 8) begin
        n_extra = $urandom_range(1, 3);
        repeat (n_extra) send_byte(BYTE_W'($urandom));
      end else if (k < 12) begin
        send_byte(SYNC_BYTE);
        n_extra = $urandom_range(1, 8);
        repeat (n_extra) send_byte(BYTE_W'($urandom));
      end else begin
        send_frame(pick_type(), pick_raw(), pick_raw(), pick_raw(), pick_raw(),
                   $urandom_range(99) < 12);
      end
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic read_full_scale(input logic [1:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("prdata", 32'(full_scale[idx]), 32'(prdata[FS_W-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_full_scale(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    full_scale[idx] = value[FS_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    read_full_scale(idx);
  endtask

  task automatic test_reset_values();
    int i;
    for (i = 0; i < 4; i++) read_full_scale(2'(i));
  endtask

  task automatic test_directed_frames();
    // Bytes ahead of any sync are ignored while hunting.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(TYPE_ACCEL, 16'h8000, 16'h7FFF, 16'h0001, 16'h8000, 1'b0);
    // An unknown type still reports its code and temperature, with zero axes.
    send_frame(8'hA7, 16'h1234, 16'hFFFF, 16'h7FFF, 16'h7FFF, 1'b0);
    send_frame(TYPE_GYRO, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 1'b1);
  endtask

  task automatic test_reset_scale_traffic();
    in_gap_pct    = 25;
    out_stall_pct = 25;
    run_traffic(230);
  endtask

  task automatic test_full_scale_max();
    wait_idle();
    // Only the low 12 bits of each write are kept.
    write_full_scale(REG_ACCEL_FS, 32'hFFFF_FFFF);
    write_full_scale(REG_GYRO_FS, 32'h0000_0FFF);
    write_full_scale(REG_ANGLE_FS, 32'hABCD_EFFF);
    write_full_scale(REG_MAG_FS, 32'h0000_0FFF);
    in_gap_pct    = 0;
    out_stall_pct = 0;
    run_traffic(230);
  endtask

  task automatic test_full_scale_min();
    wait_idle();
    write_full_scale(REG_ACCEL_FS, 32'h0000_0000);
    write_full_scale(REG_GYRO_FS, 32'h0000_0001);
    write_full_scale(REG_ANGLE_FS, 32'h0000_F000);
    write_full_scale(REG_MAG_FS, 32'h0000_0001);
    in_gap_pct    = 25;
    out_stall_pct = 25;
    run_traffic(230);
  endtask

  task automatic test_full_scale_random();
    int round;
    int i;
    for (round = 0; round < 2; round++) begin
      wait_idle();
      for (i = 0; i < 4; i++) begin
        write_full_scale(2'(i), {20'($urandom), 12'($urandom_range(1, 4095))});
      end
      run_traffic(115);
    end
  endtask

  initial begin
    rst       <= 1'b1;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    in_valid  <= 1'b0;
    rx_byte   <= '0;
    full_scale = '{ACCEL_FS_RESET, GYRO_FS_RESET, ANGLE_FS_RESET, MAG_FS_RESET};
    frame_pos  = POS_HUNT;
    frame_sum  = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_directed_frames();
    test_reset_scale_traffic();
    test_full_scale_max();
    test_full_scale_min();
    test_full_scale_random();

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      error_count++;
    end
    $display("Run covered %0d serial bytes: %0d decoded frames, %0d dropped on checksum,",
             bytes_sent, results_seen, frames_dropped);
    $display("over reset, maximum, minimum and random full scale settings.");
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
